[design/assert_macros.svh]
// Assertion macros used by the verification file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define ASSERT_CLKED(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication whose consequence must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

[design/pbns_pkg.sv]
package pbns_pkg;

  // Request kinds carried in the input tuser.
  localparam logic [1:0] REQ_SRC_WR = 2'd0;
  localparam logic [1:0] REQ_DST_WR = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEST_BASE  = 2'd0;
  localparam logic [1:0] CFG_DEST_RANGE = 2'd1;

  localparam logic [7:0] NO_MATCH_INDEX = 8'd127;
  localparam logic [8:0] DEST_RANGE_RST = 9'd256;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Per-channel sum of the two blended source colors (twice the average).
  typedef struct packed {
    logic [8:0] r;
    logic [8:0] g;
    logic [8:0] b;
  } rgb_sum_t;

  function automatic logic [19:0] chan_sq(logic [7:0] d, logic [8:0] s);
    logic [9:0]  twice;
    logic [9:0]  ext;
    logic [9:0]  mag;
    logic [19:0] sq;
    twice = {1'b0, d, 1'b0};
    ext   = {1'b0, s};
    mag   = (twice >= ext) ? (twice - ext) : (ext - twice);
    sq    = 20'(mag) * 20'(mag);
    return sq;
  endfunction

  // Squared distance between a doubled destination color and a source sum.
  function automatic logic [19:0] rgb_dist(rgb_t d, rgb_sum_t s);
    logic [21:0] total;
    total = 22'(chan_sq(d.r, s.r)) + 22'(chan_sq(d.g, s.g)) + 22'(chan_sq(d.b, s.b));
    return total[19:0];
  endfunction

endpackage

[design/palette_blend_nearest_search.sv]
// Load items (source or destination palette writes) never stall the input.
// A query reads both source colors, searches N destination entries (1 to 256, or none)
// and loads its result once the output is free; the next item is taken after that.
// The search reads the destination palette memory one entry per cycle through its
// single read port, followed by a distance stage and a compare stage.
// Reset clears control state, dest_base to 0, dest_range to 256; palettes are not cleared.
module palette_blend_nearest_search
  import pbns_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index[7:0], red[15:8], green[23:16], blue[31:24],
  // first_index[39:32], second_index[47:40]
  input  logic [47:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // nearest_index[7:0], min_distance[27:8], zero[31:28]
  output logic [31:0] m_axis_tdata,
  // found_match[0]
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CW = ($clog2(PALETTE_ENTRIES + 1) > 10) ? $clog2(PALETTE_ENTRIES + 1) : 10;
  localparam logic [CW-1:0] PAL_END = CW'(PALETTE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_SEARCH,
    S_FINISH
  } state_e;

  state_e state_q;

  // Input fields.
  logic [7:0] in_entry;
  rgb_t       in_color;
  logic [7:0] in_first;
  logic [7:0] in_second;
  logic       in_xfer;

  assign in_entry   = s_axis_tdata[7:0];
  assign in_color.r = s_axis_tdata[15:8];
  assign in_color.g = s_axis_tdata[23:16];
  assign in_color.b = s_axis_tdata[31:24];
  assign in_first   = s_axis_tdata[39:32];
  assign in_second  = s_axis_tdata[47:40];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  logic [CW-1:0] entry_w;
  logic [CW-1:0] first_w;
  logic [CW-1:0] second_w;
  logic          entry_ok;

  assign entry_w  = CW'(in_entry);
  assign first_w  = CW'(in_first);
  assign second_w = CW'(in_second);
  assign entry_ok = entry_w < PAL_END;

  // Configuration registers.
  logic [7:0] dest_base_q;
  logic [8:0] dest_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_base_q  <= '0;
      dest_range_q <= DEST_RANGE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEST_BASE:  dest_base_q  <= cfg_wdata_i[7:0];
        CFG_DEST_RANGE: dest_range_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Source palette memory. Writes happen only in idle; the memory is read every cycle,
  // but only a query uses the data and a query writes nothing, so the two never meet.
  rgb_t          src_mem [PALETTE_ENTRIES];
  rgb_t          src_rdata_q;
  logic [AW-1:0] src_raddr;
  logic [CW-1:0] sec_idx_q;

  assign src_raddr = (state_q == S_IDLE) ? first_w[AW-1:0] : sec_idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tuser == REQ_SRC_WR && entry_ok) begin
      src_mem[entry_w[AW-1:0]] <= in_color;
    end
    src_rdata_q <= src_mem[src_raddr];
  end

  // Destination palette memory, read once per cycle by the search counter.
  rgb_t          dst_mem [PALETTE_ENTRIES];
  rgb_t          dst_rdata_q;
  logic [CW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tuser == REQ_DST_WR && entry_ok) begin
      dst_mem[entry_w[AW-1:0]] <= in_color;
    end
    dst_rdata_q <= dst_mem[cnt_q[AW-1:0]];
  end

  // Query datapath.
  logic          a_oob_q;
  logic          b_oob_q;
  rgb_t          col_a_q;
  rgb_t          col_b;
  rgb_sum_t      sum_q;
  logic [CW-1:0] end_q;
  logic [CW-1:0] end_raw;
  logic [CW-1:0] end_clip;
  logic          issue;

  assign end_raw  = CW'(dest_base_q) + CW'(dest_range_q);
  assign end_clip = (end_raw > PAL_END) ? PAL_END : end_raw;
  assign col_b    = b_oob_q ? rgb_t'('0) : src_rdata_q;
  assign issue    = (state_q == S_SEARCH) && (cnt_q < end_q);

  // Pipeline: read stage (v1), distance stage (v2), then compare into the best.
  logic          v1_q;
  logic          v2_q;
  logic [CW-1:0] idx1_q;
  logic [CW-1:0] idx2_q;
  logic [19:0]   dist_q;
  logic          found_q;
  logic [19:0]   best_d_q;
  logic [CW-1:0] best_idx_q;
  logic          take;

  assign take = v2_q && (!found_q || dist_q < best_d_q);

  always_ff @(posedge clk_i) begin
    dist_q <= rgb_dist(dst_rdata_q, sum_q);
    idx1_q <= cnt_q;
    idx2_q <= idx1_q;
    if (in_xfer) begin
      sec_idx_q <= second_w;
      a_oob_q   <= !(first_w < PAL_END);
      b_oob_q   <= !(second_w < PAL_END);
    end
    if (state_q == S_RD_A) begin
      col_a_q <= a_oob_q ? rgb_t'('0) : src_rdata_q;
    end
    if (state_q == S_RD_B) begin
      sum_q.r <= 9'(col_a_q.r) + 9'(col_b.r);
      sum_q.g <= 9'(col_a_q.g) + 9'(col_b.g);
      sum_q.b <= 9'(col_a_q.b) + 9'(col_b.b);
      end_q   <= end_clip;
    end
    if (take) begin
      best_d_q   <= dist_q;
      best_idx_q <= idx2_q;
    end
  end

  // Control and output register.
  logic [7:0]  out_idx_q;
  logic [19:0] out_dist_q;
  logic        out_found_q;
  logic        out_valid_q;
  logic        out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_dist_q  <= '0;
      out_found_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (take) begin
        found_q <= 1'b1;
      end
      // In the finish state the result register is reloaded below instead.
      if (out_valid_q && m_axis_tready && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer && s_axis_tuser == REQ_QUERY) begin
            state_q <= S_RD_A;
          end
        end
        S_RD_A: begin
          state_q <= S_RD_B;
        end
        S_RD_B: begin
          cnt_q   <= CW'(dest_base_q);
          found_q <= 1'b0;
          state_q <= S_SEARCH;
        end
        S_SEARCH: begin
          if (issue) begin
            cnt_q <= cnt_q + 1'b1;
          end else if (!v1_q && !v2_q) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_found_q <= found_q;
            out_idx_q   <= found_q ? best_idx_q[7:0] : NO_MATCH_INDEX;
            out_dist_q  <= found_q ? best_d_q : '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_dist_q, out_idx_q};
  assign m_axis_tuser  = out_found_q;

endmodule

[design/pbns_checker.sv]
`include "assert_macros.svh"

module pbns_checker
  import pbns_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  logic s_xfer;

  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // A stalled result transfer keeps its payload.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // An empty search reports the fixed no-match answer.
  `ASSERT_CLKED(a_no_match, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == NO_MATCH_INDEX && m_axis_tdata[27:8] == 20'd0, "bad no-match result")

  // A query occupies the search engine, so input stalls right after it.
  `ASSERT_NEXT(a_query_busy, clk_i, rst_ni, s_xfer && s_axis_tuser == REQ_QUERY, !s_axis_tready, "input ready right after a query")

  // Load and unknown items never stall the input.
  `ASSERT_NEXT(a_load_ready, clk_i, rst_ni, s_xfer && s_axis_tuser != REQ_QUERY, s_axis_tready, "input stalled after a load")

endmodule

bind palette_blend_nearest_search pbns_checker u_pbns_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
